// ===== rtl/mm4_pkg.sv =====
// Shared types and constants for the 4x4 fixed-point matrix multiply block.
package mm4_pkg;

    localparam int MAT_DIM   = 4;
    localparam int MAT_ELEMS = 16;
    localparam int IDX_W     = 4;
    localparam int DATA_W    = 32;
    localparam int TDATA_W   = 40;
    localparam int STEP_W    = 6;

    typedef enum logic [1:0] {
        CMD_WR_LEFT  = 2'd0,
        CMD_WR_RIGHT = 2'd1,
        CMD_MAT_MUL  = 2'd2,
        CMD_SCALE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Travels alongside each multiply-add term through the pipeline.
    typedef struct packed {
        logic             first;
        logic             last;
        logic [IDX_W-1:0] index;
    } tag_t;

endpackage

// ===== rtl/mm4_mem.sv =====
// One 16-entry matrix store with registered read; unwritten entries read as zero.
module mm4_mem
    import mm4_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0]    mem [MAT_ELEMS];
    logic [MAT_ELEMS-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mm4_mac.sv =====
// Shared multiply, floor-shift, accumulate and saturate unit with output register.
module mm4_mac
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  tag_t                     in_tag,
    input  logic signed [DATA_W-1:0] op_a,
    input  logic signed [DATA_W-1:0] op_b,
    output logic                     out_valid,
    output logic [IDX_W-1:0]         out_index,
    output logic [DATA_W-1:0]        out_value,
    output logic                     out_sat,
    output logic                     out_last,
    output logic                     busy
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int ACC_W  = TERM_W + 2;

    // multiply stage
    logic signed [PROD_W-1:0] prod_reg;
    logic                     p_valid_reg;
    tag_t                     p_tag_reg;

    // accumulate stage
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     a_valid_reg;
    logic [IDX_W-1:0]         a_index_reg;

    // output register
    logic                     o_valid_reg;
    logic [IDX_W-1:0]         o_index_reg;
    logic [DATA_W-1:0]        o_value_reg;
    logic                     o_sat_reg;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  acc_next;
    logic [ACC_W-32:0]        acc_hi;
    logic                     in_range;
    logic [DATA_W-1:0]        sat_value;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    // dropping the low bits of a two's complement value rounds toward minus infinity
    assign term      = prod_reg[PROD_W-1:FRAC_BITS];
    assign acc_next  = (p_tag_reg.first ? ACC_W'(0) : acc_reg)
                     + {{2{term[TERM_W-1]}}, term};

    assign acc_hi    = acc_reg[ACC_W-1:31];
    assign in_range  = (&acc_hi) || !(|acc_hi);
    assign sat_value = in_range ? acc_reg[DATA_W-1:0]
                     : (acc_reg[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}});

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg  <= prod_next;
            p_tag_reg <= in_tag;
            if (p_valid_reg) begin
                acc_reg     <= acc_next;
                a_index_reg <= p_tag_reg.index;
            end
            o_index_reg <= a_index_reg;
            o_value_reg <= sat_value;
            o_sat_reg   <= !in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= in_valid;
            a_valid_reg <= p_valid_reg && p_tag_reg.last;
            o_valid_reg <= a_valid_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_index = o_index_reg;
    assign out_value = o_value_reg;
    assign out_sat   = o_sat_reg;
    assign out_last  = (o_index_reg == IDX_W'(MAT_ELEMS - 1));
    assign busy      = p_valid_reg || a_valid_reg;

    // a finished sum only leaves the accumulator on the last term of an element
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && p_valid_reg && !p_tag_reg.last) |=> !a_valid_reg)
        else $error("accumulator released a partial sum");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (o_valid_reg && o_sat_reg) |-> (o_value_reg == {1'b1, {(DATA_W-1){1'b0}}}
                                     || o_value_reg == {1'b0, {(DATA_W-1){1'b1}}}))
        else $error("saturated element not at a range limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv) |=> ($stable(acc_reg) && $stable(p_valid_reg)))
        else $error("pipeline moved while stalled");

endmodule

// ===== rtl/matrix_multiply_4x4.sv =====
// Top level: two 4x4 Q-format matrix stores, sequencer and shared multiply-add unit.
//
// Element writes (commands 0 and 1) give no output. A matrix product issues 64
// multiply-add steps, one per cycle unless the output stalls, through a single 32x32
// multiplier, and keeps the input closed until all steps have passed the accumulator; a
// scalar product issues 16 steps. The 16 result elements come out in column-major order
// as the accumulator finishes each one, with tlast on index 15; a stalled output holds the
// whole pipeline. Element products are floor-truncated by FRAC_BITS, sums are exact and
// saturated to 32 bits with the flag on tuser.
module matrix_multiply_4x4
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // element_index[3:0], operand_value[35:4], zeros
    input  logic [1:0]         s_tuser,   // command[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // result_index[3:0], result_value[35:4], zeros
    output logic               m_tuser,   // saturated
    output logic               m_tlast
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    cmd_t              cmd_reg, cmd_next;
    logic [DATA_W-1:0] scalar_reg, scalar_next;

    logic              s1_valid_reg;
    tag_t              s1_tag_reg;

    cmd_t              in_cmd;
    logic [IDX_W-1:0]  in_index;
    logic [DATA_W-1:0] in_value;
    logic              accept;
    logic              adv;
    logic              issue;
    logic              last_issue;
    tag_t              iss_tag;
    logic [IDX_W-1:0]  left_addr, right_addr;
    logic [DATA_W-1:0] left_rd, right_rd;
    logic [DATA_W-1:0] op_b;
    logic              mac_busy;
    logic              out_valid;
    logic [IDX_W-1:0]  out_index;
    logic [DATA_W-1:0] out_value;
    logic              out_sat;
    logic              out_last;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_index = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W+DATA_W-1:IDX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign adv      = !out_valid || m_tready;
    assign issue    = (state_reg == ST_RUN) && adv;

    // step = {col, row, e} for a matrix product, element k for a scalar product
    always_comb begin
        if (cmd_reg == CMD_SCALE) begin
            left_addr     = step_reg[IDX_W-1:0];
            right_addr    = step_reg[IDX_W-1:0];
            iss_tag.first = 1'b1;
            iss_tag.last  = 1'b1;
            iss_tag.index = step_reg[IDX_W-1:0];
            last_issue    = (step_reg[IDX_W-1:0] == IDX_W'(MAT_ELEMS - 1));
        end else begin
            left_addr     = {step_reg[1:0], step_reg[3:2]};
            right_addr    = {step_reg[5:4], step_reg[1:0]};
            iss_tag.first = (step_reg[1:0] == 2'd0);
            iss_tag.last  = (step_reg[1:0] == 2'd3);
            iss_tag.index = {step_reg[5:4], step_reg[3:2]};
            last_issue    = (step_reg == STEP_W'(MAT_ELEMS * MAT_DIM - 1));
        end
    end

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd_next    = cmd_reg;
        scalar_next = scalar_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_cmd == CMD_MAT_MUL || in_cmd == CMD_SCALE)) begin
                    cmd_next    = in_cmd;
                    scalar_next = in_value;
                    step_next   = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    step_next = step_reg + STEP_W'(1);
                    if (last_issue) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // drain ends once the read, multiply and accumulate stages are empty
                if (!s1_valid_reg && !mac_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        cmd_reg    <= cmd_next;
        scalar_reg <= scalar_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= iss_tag;
        end
    end

    mm4_mem u_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && in_cmd == CMD_WR_LEFT),
        .wr_addr (in_index),
        .wr_data (in_value),
        .rd_en   (adv),
        .rd_addr (left_addr),
        .rd_data (left_rd)
    );

    mm4_mem u_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && in_cmd == CMD_WR_RIGHT),
        .wr_addr (in_index),
        .wr_data (in_value),
        .rd_en   (adv),
        .rd_addr (right_addr),
        .rd_data (right_rd)
    );

    assign op_b = (cmd_reg == CMD_SCALE) ? scalar_reg : right_rd;

    mm4_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .in_tag    (s1_tag_reg),
        .op_a      (left_rd),
        .op_b      (op_b),
        .out_valid (out_valid),
        .out_index (out_index),
        .out_value (out_value),
        .out_sat   (out_sat),
        .out_last  (out_last),
        .busy      (mac_busy)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {{(TDATA_W-IDX_W-DATA_W){1'b0}}, out_value, out_index};
    assign m_tuser  = out_sat;
    assign m_tlast  = out_last;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!s1_valid_reg && !mac_busy))
        else $error("input open while product terms are in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_cmd == CMD_MAT_MUL || in_cmd == CMD_SCALE)) |=>
            (state_reg == ST_RUN && step_reg == '0))
        else $error("product transfer did not start a run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && last_issue) |=> (state_reg == ST_DRAIN))
        else $error("sequencer ran past the last step");

endmodule

// ===== sim/testbench.sv =====
// Stream-level testbench for the 4x4 fixed-point matrix multiply block, with a self-checking scoreboard.
module testbench
    import mm4_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 16;
    localparam int LONG_HOLD  = 400;
    localparam int TAIL_WAIT  = 100;

    typedef struct {
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic                     sat;
        logic                     last;
    } result_elem_t;

    // Tracks both stored matrices and queues the 16 elements each product must return.
    class product_scoreboard;
        logic signed [DATA_W-1:0] left_m[MAT_ELEMS];
        logic signed [DATA_W-1:0] right_m[MAT_ELEMS];
        result_elem_t expected_q[$];
        int errors;
        int n_writes;
        int n_matmul;
        int n_scale;
        int n_results;
        int n_saturated;

        function new();
            foreach (left_m[i]) begin
                left_m[i]  = '0;
                right_m[i] = '0;
            end
            errors = 0;
            n_writes = 0;
            n_matmul = 0;
            n_scale = 0;
            n_results = 0;
            n_saturated = 0;
        endfunction

        // Full-precision product, low fraction bits dropped toward minus infinity.
        function longint floor_mul(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> FRAC_BITS;
        endfunction

        function void queue_element(int k, longint sum);
            result_elem_t r;
            r.index = k[IDX_W-1:0];
            r.sat   = 1'b0;
            if (sum > 64'sd2147483647) begin
                sum   = 64'sd2147483647;
                r.sat = 1'b1;
            end else if (sum < -64'sd2147483648) begin
                sum   = -64'sd2147483648;
                r.sat = 1'b1;
            end
            r.value = sum[DATA_W-1:0];
            r.last  = (k == MAT_ELEMS - 1);
            expected_q.push_back(r);
        endfunction

        function void note_input(cmd_t cmd, logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] val);
            longint sum;
            case (cmd)
                CMD_WR_LEFT: begin
                    left_m[idx] = val;
                    n_writes++;
                end
                CMD_WR_RIGHT: begin
                    right_m[idx] = val;
                    n_writes++;
                end
                CMD_MAT_MUL: begin
                    n_matmul++;
                    for (int col = 0; col < MAT_DIM; col++) begin
                        for (int row = 0; row < MAT_DIM; row++) begin
                            sum = 0;
                            for (int e = 0; e < MAT_DIM; e++)
                                sum += floor_mul(left_m[row + e * MAT_DIM],
                                                 right_m[e + col * MAT_DIM]);
                            queue_element(row + col * MAT_DIM, sum);
                        end
                    end
                end
                default: begin
                    n_scale++;
                    for (int k = 0; k < MAT_ELEMS; k++)
                        queue_element(k, floor_mul(left_m[k], val));
                end
            endcase
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                                   logic sat, logic last);
            result_elem_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer: index %0d value %h", idx, val);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            n_results++;
            if (exp_r.sat)
                n_saturated++;
            if (idx !== exp_r.index) begin
                $error("result_index: expected %0d, got %0d", exp_r.index, idx);
                errors++;
            end
            if (val !== exp_r.value) begin
                $error("result_value: expected %h, got %h", exp_r.value, val);
                errors++;
            end
            if (sat !== exp_r.sat) begin
                $error("saturated: expected %b, got %b", exp_r.sat, sat);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last_element: expected %b, got %b", exp_r.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    cmd_t               s_tuser  = CMD_WR_LEFT;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    product_scoreboard sb = new();

    // receiver pattern state
    int rx_mode     = 0;
    int rx_seg_left = 0;
    int hold_left   = 0;
    bit stall_req   = 1'b0;

    matrix_multiply_4x4 #(.FRAC_BITS(FRAC_BITS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // element_index[3:0], operand_value[35:4], zeros
        .s_tuser  (s_tuser),   // command[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // result_index[3:0], result_value[35:4], zeros
        .m_tuser  (m_tuser),   // saturated
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Result side: check each transfer, then choose tready for the next cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[3:0], m_tdata[35:4], m_tuser, m_tlast);
            if (stall_req) begin
                hold_left = LONG_HOLD;
                stall_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (rx_seg_left == 0) begin
                    rx_mode     = $urandom_range(0, 3);
                    rx_seg_left = $urandom_range(10, 120);
                end
                rx_seg_left--;
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // Holds the item until the transfer happens; tvalid stays high for a following item.
    task automatic send_item(cmd_t cmd, logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, val, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, idx, val);
    endtask

    task automatic pause_tx(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // always lets at least one edge pass so tvalid is low for a cycle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Mix of full-range, near-unity and corner operands.
    function automatic logic signed [DATA_W-1:0] rand_operand();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: v = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0000_0001;
                    default: v = 32'h0001_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic cmd_t rand_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return CMD_WR_LEFT;
        else if (r < 80)
            return CMD_WR_RIGHT;
        else if (r < 92)
            return CMD_MAT_MUL;
        else
            return CMD_SCALE;
    endfunction

    task automatic run_random(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_item(rand_cmd(), IDX_W'($urandom_range(0, 15)), rand_operand());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_tx($urandom_range(1, 8));
        end
    endtask

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int tail;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // products on the all-zero reset matrices
        send_item(CMD_SCALE,    4'd0,  32'h7FFF_FFFF);
        send_item(CMD_MAT_MUL,  4'd0,  32'h0000_0000);
        // corner elements: full scale, most negative, unity, floor of tiny negatives
        send_item(CMD_WR_LEFT,  4'd0,  32'h7FFF_FFFF);
        send_item(CMD_WR_LEFT,  4'd15, 32'h8000_0000);
        send_item(CMD_WR_LEFT,  4'd5,  32'h0001_0000);
        send_item(CMD_WR_LEFT,  4'd10, 32'hFFFF_FFFF);
        send_item(CMD_WR_LEFT,  4'd3,  32'h0001_8000);
        send_item(CMD_WR_RIGHT, 4'd0,  32'h7FFF_FFFF);
        send_item(CMD_WR_RIGHT, 4'd15, 32'h8000_0000);
        send_item(CMD_WR_RIGHT, 4'd5,  32'hFFFF_0000);
        send_item(CMD_WR_RIGHT, 4'd10, 32'h0000_0001);
        send_item(CMD_WR_RIGHT, 4'd12, 32'h0002_0000);
        // operand field is ignored by a matrix product
        send_item(CMD_MAT_MUL,  4'd9,  32'hFFFF_FFFF);
        send_item(CMD_SCALE,    4'd0,  32'h8000_0000);
        send_item(CMD_SCALE,    4'd15, 32'h7FFF_FFFF);
        send_item(CMD_SCALE,    4'd6,  32'h0000_0001);
        send_item(CMD_SCALE,    4'd0,  32'hFFFF_FFFF);
        send_item(CMD_SCALE,    4'd0,  32'h0001_0000);
        wait_drained();

        run_random(150);
        wait_drained();

        // output held off while products keep coming: the block must back up its input
        stall_req = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_item(CMD_WR_LEFT, IDX_W'($urandom_range(0, 15)), rand_operand());
            send_item((i % 2 == 0) ? CMD_MAT_MUL : CMD_SCALE, IDX_W'($urandom_range(0, 15)),
                      rand_operand());
        end
        wait_drained();

        run_random(150);
        wait_drained();

        // watch for stray results after the last expected one
        tail = 0;
        while (tail < TAIL_WAIT) begin
            @(posedge aclk);
            tail++;
        end

        $display("Ran %0d element writes, %0d matrix products and %0d scalar products.",
                 sb.n_writes, sb.n_matmul, sb.n_scale);
        $display("Checked %0d result elements, %0d of them clipped to 32 bits.",
                 sb.n_results, sb.n_saturated);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
